@@ hdl/assert_macros.svh @@
// Assertion helpers used by the engine core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property check, ignored while reset is held.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Implication check: when cond holds, expr must hold in the same cycle.
`define ASSERT_IMPLY(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

`endif

@@ hdl/tcbe_pkg.sv @@
package tcbe_pkg;

    // field widths of the request and response words
    localparam int KIND_W  = 2;
    localparam int SIZE_W  = 28;
    localparam int CLASS_W = 7;

    // request kinds
    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FIND   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

    // sizing constants
    localparam logic [SIZE_W:0] MIN_SIZE     = 29'd8;
    localparam logic [SIZE_W:0] HEADER_BYTES = 29'd8;
    localparam int              CLASS_BIAS   = 16;

endpackage

@@ hdl/tcbe_if.sv @@
// Request channel: kind, size and class to clear.
interface tcbe_req_if;
    logic                              valid;
    logic                              ready;
    logic [tcbe_pkg::KIND_W-1:0]       kind;
    logic [tcbe_pkg::SIZE_W-1:0]       size_bytes;
    logic [tcbe_pkg::CLASS_W-1:0]      class_in;

    modport source (output valid, kind, size_bytes, class_in, input ready);
    modport sink   (input valid, kind, size_bytes, class_in, output ready);
endinterface

// Response channel: one word per request.
interface tcbe_rsp_if;
    logic                              valid;
    logic                              ready;
    logic                              found;
    logic [tcbe_pkg::CLASS_W-1:0]      class_out;
    logic [tcbe_pkg::SIZE_W-1:0]       raw_request;
    logic                              size_error;

    modport source (output valid, found, class_out, raw_request, size_error, input ready);
    modport sink   (input valid, found, class_out, raw_request, size_error, output ready);
endinterface

@@ hdl/tlsf_class_bitmap_engine_core.sv @@
// Size-class bitmap engine for a two-level segregated fit allocator.
// Request channel i_req carries one word: kind (insert, find, clear),
// size_bytes and class_in. Response channel o_rsp returns exactly one word
// per request: found, class_out, raw_request and size_error.
// Insert marks the class of a free block size, find rounds a request,
// adds the header and returns the lowest marked class at or above it,
// clear unmarks a class. Rejected requests flag size_error and leave the
// map untouched.
// One request is in flight at a time; i_req.ready is high only when idle.
// A single 32-bit lowest-set-bit unit does all the searching: first it finds
// the class of the size, then, for find, it scans the map one word at a time.
// Insert and clear go from the class step straight to the output step; a find
// that is not rejected passes through the scan step in between. The next
// request is taken in the cycle after the response is loaded, never before.
// Reset (synchronous, active low) clears the map and drops o_rsp.valid.
// When the receiver stalls, the response is held in the output register
// and a finished request waits in its last step until that register frees.
`include "assert_macros.svh"

module tlsf_class_bitmap_engine_core #(
    parameter int MAP_WORDS   = 4,
    parameter int NUM_CLASSES = 100
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    tcbe_req_if.sink      i_req,
    tcbe_rsp_if.source    o_rsp
);

    localparam int CW     = tcbe_pkg::CLASS_W;
    localparam int SW     = tcbe_pkg::SIZE_W;
    localparam int WI_W   = $clog2(MAP_WORDS);
    localparam int POS_W  = WI_W + 5;
    localparam logic [7:0]      NUM_CLS8 = 8'(NUM_CLASSES);
    localparam logic [POS_W-1:0] BIAS_P  = POS_W'(tcbe_pkg::CLASS_BIAS);
    localparam logic [WI_W-1:0] LAST_WORD = WI_W'(MAP_WORDS - 1);

    // sequencer states
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_CLASS = 2'd1;
    localparam logic [1:0] S_SCAN  = 2'd2;
    localparam logic [1:0] S_OUT   = 2'd3;

    logic [1:0]                 r_state, n_state;
    logic [tcbe_pkg::KIND_W-1:0] r_kind, n_kind;
    logic [CW-1:0]              r_cin, n_cin;
    logic [SW:0]                r_val, n_val;
    logic [WI_W-1:0]            r_word, n_word;
    logic [4:0]                 r_bit, n_bit;
    logic [31:0]                r_map [MAP_WORDS];
    logic [31:0]                n_map [MAP_WORDS];

    // result of the current request, before the output register
    logic                       r_res_found, n_res_found;
    logic [CW-1:0]              r_res_cls, n_res_cls;
    logic [SW-1:0]              r_res_raw, n_res_raw;
    logic                       r_res_err, n_res_err;

    // output register
    logic                       r_o_valid, n_o_valid;
    logic                       r_o_found, n_o_found;
    logic [CW-1:0]              r_o_cls, n_o_cls;
    logic [SW-1:0]              r_o_raw, n_o_raw;
    logic                       r_o_err, n_o_err;

    // shared lowest-set-bit unit
    logic [31:0]                ffs_in;
    logic                       ffs_any;
    logic [4:0]                 ffs_idx;

    logic [31:0]                rev_val;
    logic [SW-1:0]              v_shift;
    logic [1:0]                 sub;
    logic [7:0]                 cls8;
    logic                       cls_big;
    logic [POS_W-1:0]           pos_cls;
    logic [POS_W-1:0]           pos_cin;
    logic [POS_W-1:0]           pos_hit;
    logic [SW-1:0]              s_min;
    logic [SW:0]                s_plus3;
    logic [SW:0]                s_round;

    assign i_req.ready       = (r_state == S_IDLE) && i_rst_n;
    assign o_rsp.valid       = r_o_valid;
    assign o_rsp.found       = r_o_found;
    assign o_rsp.class_out   = r_o_cls;
    assign o_rsp.raw_request = r_o_raw;
    assign o_rsp.size_error  = r_o_err;

    // size bit-reversed so its leading one becomes the lowest set bit
    always_comb begin
        rev_val = '0;
        for (int i = 0; i < SW; i++) begin
            rev_val[i] = r_val[SW-1-i];
        end
    end

    // operand select for the shared unit
    always_comb begin
        case (r_state)
            S_CLASS: ffs_in = rev_val;
            S_SCAN:  ffs_in = r_map[r_word] & (32'hFFFF_FFFF << r_bit);
            default: ffs_in = '0;
        endcase
    end

    // lowest set bit
    always_comb begin
        ffs_any = 1'b0;
        ffs_idx = '0;
        for (int i = 31; i >= 0; i--) begin
            if (ffs_in[i]) begin
                ffs_any = 1'b1;
                ffs_idx = 5'(i);
            end
        end
    end

    // class = 4*len + sub - 16, with len = 28 - idx
    always_comb begin
        v_shift = r_val[SW-1:0] << ffs_idx;
        sub     = v_shift[SW-2:SW-3];
        cls8    = 8'd96 - {1'b0, ffs_idx, 2'b00} + {6'd0, sub};
        cls_big = (cls8 >= NUM_CLS8);
        pos_cls = POS_W'(cls8) + BIAS_P;
        pos_cin = POS_W'(r_cin) + BIAS_P;
        pos_hit = {r_word, ffs_idx};
    end

    // request rounding: max(size,8) up to a multiple of 4, plus header
    always_comb begin
        s_min   = (i_req.size_bytes < SW'(tcbe_pkg::MIN_SIZE)) ?
                  SW'(tcbe_pkg::MIN_SIZE) : i_req.size_bytes;
        s_plus3 = {1'b0, s_min} + 29'd3;
        s_round = {s_plus3[SW:2], 2'b00} + tcbe_pkg::HEADER_BYTES;
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_kind      = r_kind;
        n_cin       = r_cin;
        n_val       = r_val;
        n_word      = r_word;
        n_bit       = r_bit;
        n_map       = r_map;
        n_res_found = r_res_found;
        n_res_cls   = r_res_cls;
        n_res_raw   = r_res_raw;
        n_res_err   = r_res_err;
        n_o_valid   = r_o_valid & ~o_rsp.ready;
        n_o_found   = r_o_found;
        n_o_cls     = r_o_cls;
        n_o_raw     = r_o_raw;
        n_o_err     = r_o_err;

        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_kind  = i_req.kind;
                    n_cin   = i_req.class_in;
                    n_val   = (i_req.kind == tcbe_pkg::KIND_FIND) ?
                              s_round : {1'b0, i_req.size_bytes};
                    n_state = S_CLASS;
                end
            end
            S_CLASS: begin
                n_res_found = 1'b0;
                n_res_cls   = '0;
                n_res_raw   = '0;
                n_res_err   = 1'b0;
                n_state     = S_OUT;
                case (r_kind)
                    tcbe_pkg::KIND_INSERT: begin
                        if (r_val < tcbe_pkg::MIN_SIZE || cls_big) begin
                            n_res_err = 1'b1;
                        end else begin
                            n_map[pos_cls[POS_W-1:5]] = r_map[pos_cls[POS_W-1:5]] |
                                                        (32'h1 << pos_cls[4:0]);
                            n_res_cls = cls8[CW-1:0];
                        end
                    end
                    tcbe_pkg::KIND_FIND: begin
                        if (r_val[SW]) begin
                            n_res_err = 1'b1;
                        end else begin
                            n_res_raw = r_val[SW-1:0];
                            if (cls_big) begin
                                n_res_err = 1'b1;
                            end else begin
                                n_word  = pos_cls[POS_W-1:5];
                                n_bit   = pos_cls[4:0];
                                n_state = S_SCAN;
                            end
                        end
                    end
                    tcbe_pkg::KIND_CLEAR: begin
                        if ({1'b0, r_cin} >= NUM_CLS8) begin
                            n_res_err = 1'b1;
                        end else begin
                            n_map[pos_cin[POS_W-1:5]] = r_map[pos_cin[POS_W-1:5]] &
                                                        ~(32'h1 << pos_cin[4:0]);
                            n_res_cls = r_cin;
                        end
                    end
                    default: begin
                        n_res_err = 1'b0;
                    end
                endcase
            end
            S_SCAN: begin
                // one map word per cycle
                if (ffs_any) begin
                    n_res_found = 1'b1;
                    n_res_cls   = CW'(pos_hit - BIAS_P);
                    n_state     = S_OUT;
                end else if (r_word == LAST_WORD) begin
                    n_state = S_OUT;
                end else begin
                    n_word = r_word + 1'b1;
                    n_bit  = '0;
                end
            end
            S_OUT: begin
                if (!r_o_valid || o_rsp.ready) begin
                    n_o_valid = 1'b1;
                    n_o_found = r_res_found;
                    n_o_cls   = r_res_cls;
                    n_o_raw   = r_res_raw;
                    n_o_err   = r_res_err;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control and map registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_o_valid <= 1'b0;
            for (int i = 0; i < MAP_WORDS; i++) begin
                r_map[i] <= '0;
            end
        end else begin
            r_state   <= n_state;
            r_o_valid <= n_o_valid;
            r_map     <= n_map;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_kind      <= n_kind;
        r_cin       <= n_cin;
        r_val       <= n_val;
        r_word      <= n_word;
        r_bit       <= n_bit;
        r_res_found <= n_res_found;
        r_res_cls   <= n_res_cls;
        r_res_raw   <= n_res_raw;
        r_res_err   <= n_res_err;
        r_o_found   <= n_o_found;
        r_o_cls     <= n_o_cls;
        r_o_raw     <= n_o_raw;
        r_o_err     <= n_o_err;
    end

    // checks
    `ASSERT_CLK(a_accept_busy, i_clk, i_rst_n,
        (i_req.valid && i_req.ready) |=> (r_state == S_CLASS),
        "accepted word did not start class step")
    `ASSERT_CLK(a_rsp_from_out, i_clk, i_rst_n,
        $rose(r_o_valid) |-> ($past(r_state) == S_OUT),
        "response loaded outside the output step")
    `ASSERT_IMPLY(a_found_no_err, i_clk, i_rst_n,
        r_o_valid && r_o_found, !r_o_err && (r_o_raw != '0),
        "found response carries an error or no raw request")

endmodule
